// ===== rtl/bsa_pkg.sv =====
// Package for the bitmap sector allocator: sizes, operation and status codes,
// register indexes, the command and result beat types and a first-zero search.
// Depends on nothing.
`default_nettype none

package bsa_pkg;

    localparam int REG_W     = 18;
    localparam int SECTOR_W  = 17;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam logic [REG_W-1:0] MAX_SECTORS = REG_W'(131072);
    localparam int MAP_WORDS = int'(MAX_SECTORS) / WORD_BITS;
    localparam int ADDR_W    = $clog2(MAP_WORDS);

    localparam logic [REG_W-1:0] TOTAL_RESET      = REG_W'(131072);
    localparam logic [REG_W-1:0] FIRST_DATA_RESET = REG_W'(65);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_TOTAL      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_SECTOR = 1'b1;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TEST    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [SECTOR_W-1:0] sector_number;
    } t_cmd;

    typedef struct packed {
        logic [1:0]          status;
        logic [SECTOR_W-1:0] result_sector;
        logic                used_bit;
    } t_result;

    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bsa_map_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
// Holds the used-sector bitmap; depends on nothing.
`default_nettype none

module bsa_map_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_sector_allocator.sv =====
// Top level of the first-fit bitmap sector allocator.
// Depends on bsa_pkg and bsa_map_ram.
//
// One used bit per sector is kept in a 4096 x 32 bitmap RAM. After reset the
// block sweeps the RAM to zero, one word a cycle, and holds busy high while
// it sweeps. A command is taken when start is high and busy is low. Each command
// gives exactly one result beat, shown on o_result for a single cycle with
// o_valid high; the receiver cannot stall it. Commands that are settled by the
// registers alone (allocate with no data range, release out of range, test at
// or above the limit, the unused opcode) give their beat in the next cycle.
// Release and test read one bitmap word in the accepting cycle and give their
// beat from the S_REL or S_TEST state. Allocate reads one bitmap word a cycle
// from the first data sector's word upward, up to 4096 words, and gives its
// beat on finding a free bit or reaching the limit; busy is high while it scans.
// Configuration writes are taken at any time but should be made while idle.
`default_nettype none

module bitmap_sector_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire bsa_pkg::t_cmd                 i_cmd,
    output logic                               busy,
    output logic                               o_valid,
    output bsa_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [bsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bsa_pkg::REG_W-1:0]     i_cfg_data
);

    import bsa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_TEST  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_word, n_word;
    logic                r_first, n_first;
    logic [SECTOR_W-1:0] r_sec, n_sec;
    logic                r_valid, n_valid;
    t_result             r_res, n_res;
    logic [REG_W-1:0]    r_total;
    logic [REG_W-1:0]    r_fds;

    logic [REG_W-1:0]     lim;
    logic [REG_W-1:0]     base;
    logic [REG_W-1:0]     diff;
    logic [REG_W-1:0]     next_base;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] occ;
    logic                 found;
    logic                 last;
    logic [BIT_W-1:0]     free_idx;
    logic [REG_W-1:0]     cmd_sec;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    bsa_map_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .ADDR_W(ADDR_W)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign lim       = (r_total > MAX_SECTORS) ? MAX_SECTORS : r_total;
    assign base      = {1'b0, r_word, {BIT_W{1'b0}}};
    assign diff      = lim - base;
    assign next_base = {({1'b0, r_word} + (ADDR_W + 1)'(1)), {BIT_W{1'b0}}};
    assign lo_mask   = r_first ? ((WORD_BITS'(1) << r_fds[BIT_W-1:0]) - WORD_BITS'(1)) : '0;
    assign hi_mask   = (diff < REG_W'(WORD_BITS))
                     ? ~((WORD_BITS'(1) << diff[BIT_W-1:0]) - WORD_BITS'(1)) : '0;
    assign occ       = ram_rdata | lo_mask | hi_mask;
    assign found     = ~&occ;
    assign last      = next_base >= lim;
    assign free_idx  = first_zero(occ);
    assign cmd_sec   = {1'b0, i_cmd.sector_number};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = '0;
        ram_raddr = r_word;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                if (i_cmd.opcode == OP_ALLOC) begin
                    ram_raddr = r_fds[BIT_W +: ADDR_W];
                end else begin
                    ram_raddr = i_cmd.sector_number[BIT_W +: ADDR_W];
                end
            end
            S_SCAN: begin
                ram_raddr = r_word + ADDR_W'(1);
                if (found) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (WORD_BITS'(1) << free_idx);
                end
            end
            S_REL: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_sec[BIT_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_first = r_first;
        n_sec   = r_sec;
        n_valid = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                n_word = r_word + ADDR_W'(1);
                if (r_word == ADDR_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_sec                 = i_cmd.sector_number;
                    n_res.status          = ST_OK;
                    n_res.result_sector   = i_cmd.sector_number;
                    n_res.used_bit        = 1'b0;
                    unique case (i_cmd.opcode)
                        OP_ALLOC: begin
                            if (r_fds >= lim) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_NO_FREE;
                            end else begin
                                n_state = S_SCAN;
                                n_word  = r_fds[BIT_W +: ADDR_W];
                                n_first = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            if (cmd_sec < r_fds || cmd_sec >= lim) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_RANGE;
                            end else begin
                                n_state = S_REL;
                                n_word  = i_cmd.sector_number[BIT_W +: ADDR_W];
                            end
                        end
                        OP_TEST: begin
                            if (cmd_sec >= lim) begin
                                n_valid        = 1'b1;
                                n_res.used_bit = 1'b1;
                            end else begin
                                n_state = S_TEST;
                                n_word  = i_cmd.sector_number[BIT_W +: ADDR_W];
                            end
                        end
                        default: begin
                            n_valid      = 1'b1;
                            n_res.status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_state             = S_IDLE;
                    n_valid             = 1'b1;
                    n_res.status        = ST_OK;
                    n_res.result_sector = {r_word, free_idx};
                end else if (last) begin
                    n_state      = S_IDLE;
                    n_valid      = 1'b1;
                    n_res.status = ST_NO_FREE;
                end else begin
                    n_word  = r_word + ADDR_W'(1);
                    n_first = 1'b0;
                end
            end
            S_REL: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            S_TEST: begin
                n_state        = S_IDLE;
                n_valid        = 1'b1;
                n_res.used_bit = ram_rdata[r_sec[BIT_W-1:0]];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_word  <= '0;
            r_valid <= 1'b0;
            r_total <= TOTAL_RESET;
            r_fds   <= FIRST_DATA_RESET;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SECTOR_TOTAL) begin
                    r_total <= i_cfg_data;
                end else if (i_cfg_idx == CFG_FIRST_DATA_SECTOR) begin
                    r_fds <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_sec   <= n_sec;
        r_res   <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== tb/sv/tb_bitmap_sector_allocator.sv =====
// Self-checking testbench for the bitmap sector allocator: drives command beats, predicts
// every result beat from a shadow copy of the used map and the registers, and compares.
// Depends on bsa_pkg and bitmap_sector_allocator.
`default_nettype none

module tb_bitmap_sector_allocator;
    import bsa_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAP_SECTORS = MAP_WORDS * WORD_BITS;
    localparam int SECTOR_MAX  = MAP_SECTORS - 1;
    localparam int SETTLE_CYCLES = 64;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    t_cmd                 i_cmd;
    logic                 busy;
    logic                 o_valid;
    t_result              o_result;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;

    bit               sector_used [MAP_SECTORS];
    logic [REG_W-1:0] cur_total;
    logic [REG_W-1:0] cur_first;

    t_result pending_results [$];
    int      error_count;
    int      beats_checked;
    int      op_count [4];
    int      setting_count;
    int      burst_left;

    bitmap_sector_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Timed out with %0d result beats outstanding.", pending_results.size());
        $display("status: fail");
        $finish;
    end

    function automatic int sector_limit();
        return (cur_total > MAX_SECTORS) ? int'(MAX_SECTORS) : int'(cur_total);
    endfunction

    function automatic t_result apply_cmd(t_cmd c);
        t_result r;
        int      lim;
        int      lowest;
        int      sec;
        lim    = sector_limit();
        lowest = int'(cur_first);
        sec    = int'(c.sector_number);
        r.status        = ST_OK;
        r.result_sector = c.sector_number;
        r.used_bit      = 1'b0;
        case (c.opcode)
            OP_ALLOC: begin
                r.status = ST_NO_FREE;
                for (int s = lowest; s < lim; s++) begin
                    if (!sector_used[s]) begin
                        sector_used[s]  = 1'b1;
                        r.status        = ST_OK;
                        r.result_sector = SECTOR_W'(s);
                        break;
                    end
                end
            end
            OP_RELEASE: begin
                if (sec < lowest || sec >= lim) begin
                    r.status = ST_RANGE;
                end else begin
                    sector_used[sec] = 1'b0;
                end
            end
            OP_TEST: begin
                r.used_bit = (sec >= lim) ? 1'b1 : sector_used[sec];
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            beats_checked++;
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result beat with no command outstanding: %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status) begin
                    error_count++;
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                end
                if (o_result.result_sector !== want.result_sector) begin
                    error_count++;
                    $error("result_sector: expected %0d, got %0d",
                           want.result_sector, o_result.result_sector);
                end
                if (o_result.used_bit !== want.used_bit) begin
                    error_count++;
                    $error("used_bit: expected %0d, got %0d", want.used_bit, o_result.used_bit);
                end
            end
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [SECTOR_W-1:0] sec);
        t_cmd c;
        int   gap;
        c.opcode        = op;
        c.sector_number = sec;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_cmd(c));
        op_count[op]++;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SECTOR_TOTAL) begin
            cur_total = value;
        end else begin
            cur_first = value;
        end
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [REG_W-1:0] total, input logic [REG_W-1:0] lowest);
        wait_idle();
        write_reg(CFG_SECTOR_TOTAL, total);
        write_reg(CFG_FIRST_DATA_SECTOR, lowest);
        setting_count++;
    endtask

    task automatic test_reset_settings();
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_ALLOC, SECTOR_W'(SECTOR_MAX));
        send_cmd(OP_TEST, SECTOR_W'(65));
        send_cmd(OP_RELEASE, SECTOR_W'(65));
        send_cmd(OP_RELEASE, SECTOR_W'(65));
        send_cmd(OP_RELEASE, SECTOR_W'(64));
        send_cmd(OP_TEST, SECTOR_W'(64));
        send_cmd(OP_TEST, '0);
        send_cmd(OP_UNUSED, SECTOR_W'(SECTOR_MAX));
        send_cmd(OP_RELEASE, SECTOR_W'(SECTOR_MAX));
        send_cmd(OP_TEST, SECTOR_W'(SECTOR_MAX));
    endtask

    task automatic test_register_extremes();
        set_registers('0, '0);
        send_cmd(OP_ALLOC, SECTOR_W'(SECTOR_MAX));
        send_cmd(OP_RELEASE, '0);
        send_cmd(OP_TEST, SECTOR_W'(5));
        set_registers('1, '1);
        send_cmd(OP_ALLOC, SECTOR_W'(12345));
        send_cmd(OP_TEST, SECTOR_W'(SECTOR_MAX));
        set_registers('1, REG_W'(SECTOR_MAX));
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_ALLOC, '0);
    endtask

    task automatic run_random_phase(input logic [REG_W-1:0] total,
                                    input logic [REG_W-1:0] lowest, input int n);
        int         lo;
        int         hi;
        int         pick;
        logic [1:0] op;
        logic [SECTOR_W-1:0] sec;
        set_registers(total, lowest);
        lo = ((lowest > SECTOR_MAX) ? SECTOR_MAX : int'(lowest)) - 4;
        if (lo < 0) begin
            lo = 0;
        end
        hi = sector_limit() + 4;
        if (hi > SECTOR_MAX) begin
            hi = SECTOR_MAX;
        end
        if (hi < lo) begin
            hi = lo;
        end
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                op = OP_ALLOC;
            end else if (pick < 70) begin
                op = OP_RELEASE;
            end else if (pick < 95) begin
                op = OP_TEST;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(0, 3) == 0) begin
                sec = SECTOR_W'($urandom);
            end else begin
                sec = SECTOR_W'($urandom_range(hi, lo));
            end
            send_cmd(op, sec);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(REG_W'(131072), REG_W'(65), 24);
        run_random_phase(REG_W'(160), REG_W'(100), 24);
        run_random_phase('1, REG_W'(131050), 24);
        run_random_phase(REG_W'(1000), '0, 24);
        run_random_phase(REG_W'(48), REG_W'(40), 24);
    endtask

    initial begin : main_sequence
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        cur_total     = TOTAL_RESET;
        cur_first     = FIRST_DATA_RESET;
        sector_used   = '{default: 1'b0};
        error_count   = 0;
        beats_checked = 0;
        setting_count = 1;
        op_count      = '{default: 0};
        burst_left    = $urandom_range(0, 12);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        test_reset_settings();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d allocate, %0d release, %0d test and %0d unused-opcode commands.",
                 op_count[OP_ALLOC], op_count[OP_RELEASE], op_count[OP_TEST],
                 op_count[OP_UNUSED]);
        $display("Checked %0d result beats over %0d register settings, %0d mismatches.",
                 beats_checked, setting_count, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== bitmap_sector_allocator.f =====
rtl/bsa_pkg.sv
rtl/bsa_map_ram.sv
rtl/bitmap_sector_allocator.sv
tb/sv/tb_bitmap_sector_allocator.sv
